@@ rtl/scms_pkg.sv @@
// Shared types, codes and fixed-point helpers for the sparse column store.
// No dependencies; imported by scms_mul, the top level and the testbench.
package scms_pkg;

	localparam int ROW_W = 10;
	localparam int VAL_W = 32;
	localparam int ENT_W = ROW_W + VAL_W;

	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_CLEAR = 3'd2;
	localparam logic [2:0] MODE_SCALE = 3'd3;
	localparam logic [2:0] MODE_MUL   = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic CFG_SIZE = 1'b0;
	localparam logic CFG_DIMS = 1'b1;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_HIT,
		ST_INS,
		ST_SC_FILL,
		ST_SC_LOAD,
		ST_SC_RUN
	} state_t;

	typedef struct packed {
		logic vld;
		logic last;
	} tag_t;

	// round half up at bit 15, then saturate
	function automatic logic signed [VAL_W-1:0] qround(input logic signed [63:0] p);
		logic signed [63:0] q;
		q = p + 64'sd32768;
		if (q[63:47] == {17{q[63]}})
			return q[47:16];
		else if (q[63])
			return VAL_MIN;
		else
			return VAL_MAX;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1])
			return s[VAL_W] ? VAL_MIN : VAL_MAX;
		else
			return s[VAL_W-1:0];
	endfunction

endpackage

@@ rtl/scms_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module scms_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/scms_mul.sv @@
// Two-stage Q16.16 multiply lanes: products, then rounding and saturation.
// Depends on scms_pkg.
module scms_mul import scms_pkg::*; #(
	parameter int AW = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tag_t                    in_tag,
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] x1,
	input  logic signed [VAL_W-1:0] x2,
	input  logic signed [VAL_W-1:0] x3,
	input  logic [ROW_W-1:0]        in_row,
	input  logic [AW-1:0]           in_addr,
	output tag_t                    out_tag,
	output logic signed [VAL_W-1:0] y1,
	output logic signed [VAL_W-1:0] y2,
	output logic signed [VAL_W-1:0] y3,
	output logic [ROW_W-1:0]        out_row,
	output logic [AW-1:0]           out_addr
);

	tag_t                tag_s1;
	logic signed [63:0]  p1_s1, p2_s1, p3_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [AW-1:0]       addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			out_tag <= '0;
		end else begin
			tag_s1  <= in_tag;
			out_tag <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1    <= 64'(a) * 64'(x1);
		p2_s1    <= 64'(a) * 64'(x2);
		p3_s1    <= 64'(a) * 64'(x3);
		row_s1   <= in_row;
		addr_s1  <= in_addr;
		y1       <= qround(p1_s1);
		y2       <= qround(p2_s1);
		y3       <= qround(p3_s1);
		out_row  <= row_s1;
		out_addr <= addr_s1;
	end

endmodule

@@ rtl/sparse_column_matrix_store_spmv.sv @@
// Top level of the sparse column matrix store: sequencer, fill and entry RAMs.
// Depends on scms_pkg, scms_ram and scms_mul.
//
// Usage: a request is taken at a clock edge with start high and busy low.
// Results appear on the out_* ports for one cycle each, marked by
// result_valid; the receiver cannot stall, so nothing is held back.
// Add and read: one result after a scan of the stored entries (at most
// ENTRIES_PER_COLUMN); an add to a column with no entries first stores a
// zero diagonal entry, unless the new entry is itself the diagonal one.
// Column multiply: one result per stored entry, last on the final one
// (a single result for an empty column); the entry RAM read port gives
// one entry per cycle and the products run through a two-stage
// multiplier. Scale: walks every column, multiplying each filled column's
// entries in place, one acknowledge result. Clear: a pass over every
// column of the fill RAM, then an acknowledge.
// Bad indices and unknown modes answer straight from idle with status 1.
// After reset the same clearing pass runs with busy high;
// configuration writes (cfg_we, cfg_index, cfg_data) are taken at any time.
module sparse_column_matrix_store_spmv import scms_pkg::*; #(
	parameter int COLUMNS            = 1024,
	parameter int ENTRIES_PER_COLUMN = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [10:0]             cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              mode,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [ROW_W-1:0]        col_index,
	input  logic signed [VAL_W-1:0] value,
	input  logic signed [VAL_W-1:0] value_second,
	input  logic signed [VAL_W-1:0] value_third,
	output logic                    result_valid,
	output logic [ROW_W-1:0]        out_row,
	output logic signed [VAL_W-1:0] out_value,
	output logic signed [VAL_W-1:0] out_second,
	output logic signed [VAL_W-1:0] out_third,
	output logic                    found,
	output logic [1:0]              status,
	output logic                    last
);

	localparam int CW = $clog2(COLUMNS);
	localparam int FW = $clog2(ENTRIES_PER_COLUMN + 1);
	localparam int AW = $clog2(COLUMNS * ENTRIES_PER_COLUMN);

	state_t state_q, nxt;

	logic [10:0] size_q;
	logic [1:0]  dims_q;

	logic [2:0]              mode_q;
	logic [ROW_W-1:0]        row_q, col_q;
	logic signed [VAL_W-1:0] v1_q, v2_q, v3_q;
	logic [CW-1:0]           cnt_q;
	logic                    clr_ack_q;
	logic [FW-1:0]           fill_q, idx_q, hit_idx_q;
	logic signed [VAL_W-1:0] hit_val_q;

	logic            iss_s1, last_s1;
	logic [FW-1:0]   idx_s1;
	logic [AW-1:0]   addr_s1;

	logic            f_we;
	logic [CW-1:0]   f_waddr, f_raddr;
	logic [FW-1:0]   f_wdata, f_rdata;
	logic            e_we;
	logic [AW-1:0]   e_waddr, e_raddr;
	logic [ENT_W-1:0] e_wdata, e_rdata;

	logic [CW-1:0]           colsel;
	logic                    issue, cnt_last, row_ok, col_ok, hit, mul_mode;
	logic [ROW_W-1:0]        e_rrow;
	logic signed [VAL_W-1:0] e_rval, sum;

	tag_t                    mi_tag, mo_tag;
	logic signed [VAL_W-1:0] mo_y1, mo_y2, mo_y3;
	logic [ROW_W-1:0]        mo_row;
	logic [AW-1:0]           mo_addr;

	logic                    em_vld, em_found, em_last;
	logic [ROW_W-1:0]        em_row;
	logic signed [VAL_W-1:0] em_v1, em_v2, em_v3;
	logic [1:0]              em_status;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [FW-1:0] i);
		return AW'(c) * AW'(ENTRIES_PER_COLUMN) + AW'(i);
	endfunction

	scms_ram #(.W(FW), .D(COLUMNS)) u_fill (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	scms_ram #(.W(ENT_W), .D(COLUMNS * ENTRIES_PER_COLUMN)) u_entry (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	assign e_rrow   = e_rdata[ENT_W-1:VAL_W];
	assign e_rval   = e_rdata[VAL_W-1:0];
	assign mul_mode = (mode_q == MODE_MUL) || (mode_q == MODE_SCALE);
	assign mi_tag   = '{vld: iss_s1 && mul_mode, last: last_s1};

	scms_mul #(.AW(AW)) u_mul (
		.clk(clk), .arst_n(arst_n), .in_tag(mi_tag), .a(e_rval),
		.x1(v1_q), .x2(v2_q), .x3(v3_q), .in_row(e_rrow), .in_addr(addr_s1),
		.out_tag(mo_tag), .y1(mo_y1), .y2(mo_y2), .y3(mo_y3),
		.out_row(mo_row), .out_addr(mo_addr)
	);

	assign busy     = (state_q != ST_IDLE);
	assign colsel   = (mode_q == MODE_SCALE) ? cnt_q : CW'(col_q);
	assign cnt_last = (cnt_q == CW'(COLUMNS - 1));
	assign issue    = ((state_q == ST_SCAN) || (state_q == ST_SC_RUN)) && (idx_q < fill_q);
	assign row_ok   = ({1'b0, row_index} < size_q) && (32'(row_index) < 32'(COLUMNS));
	assign col_ok   = ({1'b0, col_index} < size_q) && (32'(col_index) < 32'(COLUMNS));
	assign hit      = iss_s1 && (e_rrow == row_q);
	assign sum      = sat_add(hit_val_q, v1_q);
	assign f_raddr  = (state_q == ST_SC_FILL) ? cnt_q : CW'(col_index);
	assign e_raddr  = addr_of(colsel, idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= nxt;
	end

	always_comb begin
		nxt       = state_q;
		em_vld    = 1'b0;
		em_row    = '0;
		em_v1     = '0;
		em_v2     = '0;
		em_v3     = '0;
		em_found  = 1'b0;
		em_status = STAT_OK;
		em_last   = 1'b1;
		f_we      = 1'b0;
		f_waddr   = CW'(col_q);
		f_wdata   = '0;
		e_we      = 1'b0;
		e_waddr   = addr_of(CW'(col_q), hit_idx_q);
		e_wdata   = {row_q, sum};
		unique case (state_q)
			ST_CLR: begin
				f_we    = 1'b1;
				f_waddr = cnt_q;
				if (cnt_last) begin
					nxt    = ST_IDLE;
					em_vld = clr_ack_q;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (mode) inside
						MODE_CLEAR: nxt = ST_CLR;
						MODE_SCALE: nxt = ST_SC_FILL;
						MODE_ADD, MODE_READ: begin
							if (col_ok && row_ok)
								nxt = ST_LOAD;
							else begin
								em_vld    = 1'b1;
								em_status = STAT_BAD;
							end
						end
						MODE_MUL: begin
							if (col_ok)
								nxt = ST_LOAD;
							else begin
								em_vld    = 1'b1;
								em_status = STAT_BAD;
							end
						end
						default: begin
							em_vld    = 1'b1;
							em_status = STAT_BAD;
						end
					endcase
				end
			end
			ST_LOAD: begin
				if (f_rdata != '0)
					nxt = ST_SCAN;
				else if (mode_q == MODE_ADD)
					nxt = ST_INS;
				else begin
					nxt    = ST_IDLE;
					em_vld = 1'b1;
					if (mode_q == MODE_READ)
						em_row = row_q;
				end
			end
			ST_SCAN: begin
				if (mode_q == MODE_MUL) begin
					if (mo_tag.vld) begin
						em_vld   = 1'b1;
						em_row   = mo_row;
						em_v1    = mo_y1;
						em_v2    = (dims_q[1]) ? mo_y2 : '0;
						em_v3    = (dims_q == 2'd3) ? mo_y3 : '0;
						em_found = 1'b1;
						em_last  = mo_tag.last;
						if (mo_tag.last)
							nxt = ST_IDLE;
					end
				end else if (hit)
					nxt = ST_HIT;
				else if (iss_s1 && last_s1) begin
					if (mode_q == MODE_READ) begin
						nxt    = ST_IDLE;
						em_vld = 1'b1;
						em_row = row_q;
					end else if (fill_q >= FW'(ENTRIES_PER_COLUMN)) begin
						nxt       = ST_IDLE;
						em_vld    = 1'b1;
						em_row    = row_q;
						em_status = STAT_FULL;
					end else
						nxt = ST_INS;
				end
			end
			ST_HIT: begin
				nxt      = ST_IDLE;
				em_vld   = 1'b1;
				em_row   = row_q;
				em_found = 1'b1;
				if (mode_q == MODE_READ)
					em_v1 = hit_val_q;
				else begin
					e_we  = 1'b1;
					em_v1 = sum;
				end
			end
			ST_INS: begin
				if (fill_q == '0) begin
					e_we    = 1'b1;
					e_waddr = addr_of(CW'(col_q), '0);
					e_wdata = {col_q, (row_q == col_q) ? v1_q : '0};
					if (row_q == col_q) begin
						f_we    = 1'b1;
						f_wdata = FW'(1);
						nxt     = ST_IDLE;
						em_vld  = 1'b1;
						em_row  = row_q;
						em_v1   = v1_q;
					end
				end else begin
					e_we    = 1'b1;
					e_waddr = addr_of(CW'(col_q), fill_q);
					e_wdata = {row_q, v1_q};
					f_we    = 1'b1;
					f_wdata = fill_q + FW'(1);
					nxt     = ST_IDLE;
					em_vld  = 1'b1;
					em_row  = row_q;
					em_v1   = v1_q;
				end
			end
			ST_SC_FILL: nxt = ST_SC_LOAD;
			ST_SC_LOAD: begin
				if (f_rdata != '0)
					nxt = ST_SC_RUN;
				else if (cnt_last) begin
					nxt    = ST_IDLE;
					em_vld = 1'b1;
				end else
					nxt = ST_SC_FILL;
			end
			ST_SC_RUN: begin
				if (mo_tag.vld) begin
					e_we    = 1'b1;
					e_waddr = mo_addr;
					e_wdata = {mo_row, mo_y1};
					if (mo_tag.last) begin
						if (cnt_last) begin
							nxt    = ST_IDLE;
							em_vld = 1'b1;
						end else
							nxt = ST_SC_FILL;
					end
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 11'd1024;
			dims_q <= 2'd1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SIZE)
				size_q <= cfg_data;
			else if (cfg_index == CFG_DIMS)
				dims_q <= (cfg_data[1:0] == 2'd0) ? 2'd1 : cfg_data[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			clr_ack_q    <= 1'b0;
			idx_q        <= '0;
			fill_q       <= '0;
			iss_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			iss_s1       <= issue;
			result_valid <= em_vld;
			if (issue)
				idx_q <= idx_q + FW'(1);
			unique case (state_q)
				ST_CLR: cnt_q <= cnt_q + CW'(1);
				ST_IDLE: begin
					cnt_q     <= '0;
					clr_ack_q <= (mode == MODE_CLEAR);
				end
				ST_LOAD, ST_SC_LOAD: begin
					fill_q <= f_rdata;
					idx_q  <= '0;
					if (state_q == ST_SC_LOAD && f_rdata == '0)
						cnt_q <= cnt_q + CW'(1);
				end
				ST_INS: begin
					if (fill_q == '0)
						fill_q <= FW'(1);
				end
				ST_SC_RUN: begin
					if (mo_tag.vld && mo_tag.last)
						cnt_q <= cnt_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= mode;
			row_q  <= row_index;
			col_q  <= col_index;
			v1_q   <= value;
			v2_q   <= value_second;
			v3_q   <= value_third;
		end
		if (state_q == ST_SCAN && hit) begin
			hit_val_q <= e_rval;
			hit_idx_q <= idx_s1;
		end
		idx_s1     <= idx_q;
		last_s1    <= ((idx_q + FW'(1)) == fill_q);
		addr_s1    <= e_raddr;
		out_row    <= em_row;
		out_value  <= em_v1;
		out_second <= em_v2;
		out_third  <= em_v3;
		found      <= em_found;
		status     <= em_status;
		last       <= em_last;
	end

endmodule

@@ tb/testbench.sv @@
// Testbench for the sparse column matrix store: random and directed requests
// checked against a behavioral model of the column store. Depends on scms_pkg and sparse_column_matrix_store_spmv.
module testbench;
	import scms_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCOL = 1024;
	localparam int NENT = 16;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic signed [VAL_W-1:0] v1, v2, v3;
		logic fnd;
		logic [1:0] st;
		logic lst;
	} answer_t;

	logic clk = 0, arst_n = 0, cfg_we = 0, cfg_index = 0, start = 0;
	logic [10:0] cfg_data = '0;
	logic [2:0] mode = '0;
	logic [ROW_W-1:0] row_index = '0, col_index = '0;
	logic signed [VAL_W-1:0] value = '0, value_second = '0, value_third = '0;
	logic busy, result_valid, found, last;
	logic [ROW_W-1:0] out_row;
	logic signed [VAL_W-1:0] out_value, out_second, out_third;
	logic [1:0] status;

	sparse_column_matrix_store_spmv uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// model state
	logic [ROW_W-1:0] m_rows [NCOL][NENT];
	logic signed [VAL_W-1:0] m_vals [NCOL][NENT];
	int m_fill [NCOL];
	int m_size = 1024;
	int m_dims = 1;
	answer_t pending[$];
	int errors = 0;
	int idle_pct = 0;

	function automatic logic signed [VAL_W-1:0] sat64(longint v);
		if (v > 64'sd2147483647) return VAL_MAX;
		if (v < -64'sd2147483648) return VAL_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] fxmul(longint a, longint b);
		longint q;
		q = a * b + 32768;
		return sat64(q >>> 16);
	endfunction

	function automatic answer_t ans(int r, longint a, longint b, longint c,
		bit f, logic [1:0] s, bit l);
		answer_t x;
		x.row = r; x.v1 = a; x.v2 = b; x.v3 = c; x.fnd = f; x.st = s; x.lst = l;
		return x;
	endfunction

	task automatic predict(logic [2:0] md, int r, int c, longint a, longint b, longint d);
		int i, f, dd;
		if (md == MODE_CLEAR || md == MODE_SCALE) begin
			for (int k = 0; k < NCOL; k++)
				if (md == MODE_CLEAR) m_fill[k] = 0;
				else for (int j = 0; j < m_fill[k]; j++) m_vals[k][j] = fxmul(m_vals[k][j], a);
			pending.push_back(ans(0, 0, 0, 0, 0, STAT_OK, 1));
			return;
		end
		if (md > MODE_MUL || c >= m_size || (md != MODE_MUL && r >= m_size)) begin
			pending.push_back(ans(0, 0, 0, 0, 0, STAT_BAD, 1));
			return;
		end
		f = m_fill[c];
		if (md == MODE_MUL) begin
			dd = m_dims == 0 ? 1 : m_dims;
			if (f == 0) pending.push_back(ans(0, 0, 0, 0, 0, STAT_OK, 1));
			for (i = 0; i < f; i++)
				pending.push_back(ans(m_rows[c][i], fxmul(m_vals[c][i], a),
					dd >= 2 ? fxmul(m_vals[c][i], b) : 0,
					dd >= 3 ? fxmul(m_vals[c][i], d) : 0, 1, STAT_OK, i + 1 == f));
			return;
		end
		for (i = 0; i < f; i++) if (m_rows[c][i] == r) break;
		if (md == MODE_READ) begin
			if (i < f) pending.push_back(ans(r, m_vals[c][i], 0, 0, 1, STAT_OK, 1));
			else pending.push_back(ans(r, 0, 0, 0, 0, STAT_OK, 1));
			return;
		end
		if (i < f) begin
			m_vals[c][i] = sat64(longint'(m_vals[c][i]) + a);
			pending.push_back(ans(r, m_vals[c][i], 0, 0, 1, STAT_OK, 1));
			return;
		end
		if (f == 0) begin
			m_rows[c][0] = c; m_vals[c][0] = 0; f = 1;
			if (r == c) begin
				m_fill[c] = 1; m_vals[c][0] = a;
				pending.push_back(ans(r, a, 0, 0, 0, STAT_OK, 1));
				return;
			end
		end
		if (f >= NENT) begin
			pending.push_back(ans(r, 0, 0, 0, 0, STAT_FULL, 1));
			return;
		end
		m_rows[c][f] = r; m_vals[c][f] = a; m_fill[c] = f + 1;
		pending.push_back(ans(r, a, 0, 0, 0, STAT_OK, 1));
	endtask

	// start stays high between back-to-back requests; idling and drain drop it
	task automatic send(logic [2:0] md, int r, int c, logic [31:0] a,
		logic [31:0] b = 0, logic [31:0] d = 0);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		mode <= md; row_index <= r; col_index <= c;
		value <= a; value_second <= b; value_third <= d; start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict(md, r & 1023, c & 1023, signed'(a), signed'(b), signed'(d));
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_reg(logic idx, int v);
		drain();
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_SIZE) m_size = v; else m_dims = v;
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (result_valid) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result row %0d value %0h", $time, out_row, out_value);
				errors++;
			end else begin
				e = pending.pop_front();
				if (out_row !== e.row || out_value !== e.v1 || out_second !== e.v2 ||
					out_third !== e.v3 || found !== e.fnd || status !== e.st || last !== e.lst) begin
					$display("%0t: expected row %0d val %0h %0h %0h f%0d s%0d l%0d", $time,
						e.row, e.v1, e.v2, e.v3, e.fnd, e.st, e.lst);
					$display("%0t: actual   row %0d val %0h %0h %0h f%0d s%0d l%0d", $time,
						out_row, out_value, out_second, out_third, found, status, last);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0003_0000);
			3: return -$urandom_range(32'h0003_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send(MODE_READ, 0, 0, 0);
		send(MODE_MUL, 0, 5, 32'h10000);
		send(MODE_ADD, 5, 5, 32'h7FFF_FFFF);
		send(MODE_ADD, 5, 5, 32'h7FFF_FFFF);
		send(MODE_ADD, 1023, 7, 32'h8000_0000);
		send(MODE_ADD, 1023, 7, 32'h8000_0000);
		send(MODE_READ, 7, 7, 0);
		send(MODE_READ, 3, 7, 0);
		for (int i = 0; i < 16; i++) send(MODE_ADD, 100 + i, 9, 32'h18000 + i);
		send(MODE_MUL, 0, 9, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send(MODE_SCALE, 0, 0, 32'hFFFE_0000);
		send(MODE_MUL, 0, 7, 32'h7FFF_FFFF);
		for (int m = 5; m < 8; m++) send(m, 1023, 1023, 32'hFFFF_FFFF);
		send(MODE_CLEAR, 0, 0, 0);
		send(MODE_READ, 5, 5, 0);
	endtask

	task automatic test_random(int n, int ncols);
		int c;
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(ncols - 1);
			case ($urandom_range(99)) inside
				[0:44]: send(MODE_ADD, $urandom_range(1) ? c : $urandom_range(1023), c, rnd_val());
				[45:64]: send(MODE_READ, $urandom_range(1023), c, 0);
				[65:84]: send(MODE_MUL, $urandom, c, rnd_val(), rnd_val(), rnd_val());
				[85:88]: send(MODE_SCALE, $urandom, $urandom, rnd_val());
				89: send(MODE_CLEAR, $urandom, $urandom, $urandom);
				[90:94]: send($urandom_range(7), $urandom, $urandom, $urandom, $urandom, $urandom);
				default: send(MODE_READ, $urandom_range(1023), $urandom_range(1023), $urandom);
			endcase
		end
	endtask

	task automatic test_config();
		set_reg(CFG_DIMS, 3);
		test_random(60, 12);
		set_reg(CFG_DIMS, 0);
		set_reg(CFG_SIZE, 1);
		test_random(20, 3);
		set_reg(CFG_SIZE, 700);
		set_reg(CFG_DIMS, 2);
		test_random(60, 1024);
		set_reg(CFG_SIZE, 1024);
		set_reg(CFG_DIMS, 3);
	endtask

	initial begin
		for (int k = 0; k < NCOL; k++) m_fill[k] = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		test_directed();
		idle_pct = 0;
		test_random(80, 8);
		test_config();
		idle_pct = 59;
		test_random(80, 6);
		drain();
		idle_pct = 26;
		test_random(80, 16);
		idle_pct = 0;
		drain();
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

@@ files.f @@
rtl/scms_pkg.sv
rtl/scms_ram.sv
rtl/scms_mul.sv
rtl/sparse_column_matrix_store_spmv.sv
tb/testbench.sv
